>>> hw/rtl/sscs_pkg.sv
package sscs_pkg;

   // default store depth
   localparam int MAX_HIST_BYTES_DEF = 128;

   // request codes
   localparam logic [2:0] REQ_TRIGGER = 3'd0;
   localparam logic [2:0] REQ_TICK    = 3'd1;
   localparam logic [2:0] REQ_REPLY   = 3'd2;
   localparam logic [2:0] REQ_FETCH   = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   // command indexes
   localparam logic [2:0] CMD_READ = 3'd6;
   localparam logic [2:0] CMD_NONE = 3'd7;

   // sensor reply codes
   localparam logic [7:0] RES_BUSY  = 8'h31;
   localparam logic [7:0] RES_READY = 8'hF3;

   // crc-16 modbus
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // csr register indexes
   localparam logic [2:0] REG_POWER_CMD = 3'd0;
   localparam logic [2:0] REG_HIST_CMD  = 3'd1;
   localparam logic [2:0] REG_HIST_LEN  = 3'd2;
   localparam logic [2:0] REG_POLL_INT  = 3'd3;
   localparam logic [2:0] REG_RETRY_LIM = 3'd4;

   // csr reset values
   localparam logic [7:0] POWER_CMD_RST = 8'd3;
   localparam logic [7:0] HIST_CMD_RST  = 8'd48;
   localparam logic [7:0] HIST_LEN_RST  = 8'd86;
   localparam logic [7:0] POLL_INT_RST  = 8'd3;
   localparam logic [7:0] RETRY_LIM_RST = 8'd150;

   // shortest histogram, two of which are checksum bytes
   localparam logic [7:0] HIST_LEN_MIN = 8'd3;

   // one byte of reflected crc, eight shift steps unrolled
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/sscs_req_if.sv
interface sscs_req_if import sscs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [2:0] cmd_index;
   logic [7:0] rx_byte;
   logic [6:0] byte_index;

   modport source (output valid, req_type, cmd_index, rx_byte, byte_index, input ready);
   modport sink   (input valid, req_type, cmd_index, rx_byte, byte_index, output ready);
endinterface

>>> hw/rtl/sscs_rsp_if.sv
interface sscs_rsp_if import sscs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       accepted;
   logic       is_idle;
   logic       hist_valid;
   logic       crc_ok;
   logic [7:0] read_data;

   modport source (output valid, tx_valid, tx_byte, accepted, is_idle, hist_valid, crc_ok,
                   read_data, input ready);
   modport sink   (input valid, tx_valid, tx_byte, accepted, is_idle, hist_valid, crc_ok,
                   read_data, output ready);
endinterface

>>> hw/rtl/spi_sensor_command_sequencer_unit.sv
// channel   direction  handshake            payload
// req_chan  in         valid/ready          req_type, cmd_index, rx_byte, byte_index
// rsp_chan  out        valid/ready          tx_valid, tx_byte, accepted, is_idle,
//                                           hist_valid, crc_ok, read_data
// csr_*     in         apb write/read       five 8-bit registers at byte address 4*i
//
// one item per cycle sustained while rsp_ready stays high; each item gives one result after
// acceptance (sequencer state, middle stage and store read data register at acceptance, the
// result register follows), so the rate is set by the state update and crc byte step
// reset is synchronous and clears the sequencer and csrs; the histogram store is not cleared
// rsp_ready low holds the result register, the middle stage fills, then req_ready drops
module spi_sensor_command_sequencer_unit import sscs_pkg::*; #(
   parameter int MAX_HIST_BYTES = MAX_HIST_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   sscs_req_if.sink          req_chan,
   sscs_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int AW = $clog2(MAX_HIST_BYTES);
   localparam logic [8:0] MAX_LEN = 9'(MAX_HIST_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_POLL_REPLY,
      PH_DATA_REPLY,
      PH_RECEIVE,
      PH_EVALUATE
   } phase_type;

   // configuration
   logic [7:0] power_cmd_ff, hist_cmd_ff, hist_len_ff, poll_int_ff, retry_lim_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic [2:0]  active_cmd_ff, active_cmd_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic [7:0]  retry_count_ff, retry_count_in;
   logic [7:0]  rx_count_ff, rx_count_in;
   logic [15:0] crc_ff, crc_in;

   // middle stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_txv_ff, s1_acc_ff, s1_idle_ff, s1_fetch_ff, s1_read_ff;
   logic [7:0]  s1_txb_ff;
   logic [15:0] s1_crc_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_txv_ff, out_acc_ff, out_idle_ff, out_hv_ff, out_ok_ff;
   logic [7:0]  out_txb_ff, out_rd_ff;

   // histogram store
   logic [7:0]    hist_mem [MAX_HIST_BYTES];
   logic [7:0]    rda_ff, rdb_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra, mem_rb;

   // combinational results of the accepted item
   logic       txv, acc, fetch_hit, read_hit;
   logic [7:0] txb, len, tick_inc, retry_inc;
   logic       req_fire, out_free, s1_free, cfg_we;

   // flow control
   assign out_free        = !out_valid_ff || rsp_chan.ready;
   assign s1_free         = !s1_valid_ff || out_free;
   assign req_chan.ready  = s1_free;
   assign req_fire        = req_chan.valid && s1_free;
   assign s1_valid_in     = s1_free ? req_fire : s1_valid_ff;
   assign out_valid_in    = out_free ? s1_valid_ff : out_valid_ff;

   // csr access
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_POWER_CMD: csr_prdata = {24'h0, power_cmd_ff};
         REG_HIST_CMD:  csr_prdata = {24'h0, hist_cmd_ff};
         REG_HIST_LEN:  csr_prdata = {24'h0, hist_len_ff};
         REG_POLL_INT:  csr_prdata = {24'h0, poll_int_ff};
         REG_RETRY_LIM: csr_prdata = {24'h0, retry_lim_ff};
         default:       csr_prdata = 32'h0;
      endcase
   end

   // effective histogram length, clamped to the minimum and to the store
   always_comb begin
      if (hist_len_ff < HIST_LEN_MIN) begin
         len = HIST_LEN_MIN;
      end else if ({1'b0, hist_len_ff} > MAX_LEN) begin
         len = MAX_LEN[7:0];
      end else begin
         len = hist_len_ff;
      end
   end

   assign tick_inc  = (tick_count_ff == 8'hFF) ? tick_count_ff : tick_count_ff + 8'd1;
   assign retry_inc = (retry_count_ff == 8'hFF) ? retry_count_ff : retry_count_ff + 8'd1;

   // sequencer next state and result fields
   always_comb begin
      phase_in       = phase_ff;
      active_cmd_in  = active_cmd_ff;
      tick_count_in  = tick_count_ff;
      retry_count_in = retry_count_ff;
      rx_count_in    = rx_count_ff;
      crc_in         = crc_ff;
      txv            = 1'b0;
      txb            = 8'h00;
      acc            = 1'b0;
      fetch_hit      = 1'b0;
      read_hit       = 1'b0;
      mem_we         = 1'b0;
      mem_wa         = AW'(rx_count_ff);
      mem_ra         = AW'(req_chan.byte_index);
      mem_rb         = AW'(len - 8'd1);
      if (req_fire) begin
         unique case (req_chan.req_type)
            REQ_TRIGGER: begin
               if (phase_ff == PH_IDLE && req_chan.cmd_index != CMD_NONE) begin
                  active_cmd_in  = req_chan.cmd_index;
                  tick_count_in  = 8'h00;
                  retry_count_in = 8'h00;
                  phase_in       = PH_WAIT;
                  acc            = 1'b1;
               end
            end
            REQ_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  tick_count_in = tick_inc;
                  if (tick_inc > poll_int_ff) begin
                     tick_count_in  = 8'h00;
                     retry_count_in = retry_inc;
                     txv            = 1'b1;
                     txb            = (active_cmd_ff == CMD_READ) ? hist_cmd_ff : power_cmd_ff;
                     phase_in       = PH_POLL_REPLY;
                  end
               end
            end
            REQ_REPLY: begin
               unique case (phase_ff)
                  PH_POLL_REPLY: begin
                     if (req_chan.rx_byte == RES_READY) begin
                        txv = 1'b1;
                        if (active_cmd_ff == CMD_READ) begin
                           rx_count_in = 8'h00;
                           crc_in      = CRC_INIT;
                           txb         = hist_cmd_ff;
                           phase_in    = PH_RECEIVE;
                        end else begin
                           txb      = {5'h00, active_cmd_ff} + 8'd2;
                           phase_in = PH_DATA_REPLY;
                        end
                     end else if (retry_count_ff > retry_lim_ff) begin
                        phase_in       = PH_IDLE;
                        active_cmd_in  = CMD_NONE;
                        tick_count_in  = 8'h00;
                        retry_count_in = 8'h00;
                        rx_count_in    = 8'h00;
                     end else begin
                        phase_in = PH_WAIT;
                     end
                  end
                  PH_DATA_REPLY: begin
                     if (req_chan.rx_byte == RES_BUSY && retry_count_ff <= retry_lim_ff) begin
                        phase_in = PH_WAIT;
                     end else begin
                        phase_in       = PH_IDLE;
                        active_cmd_in  = CMD_NONE;
                        tick_count_in  = 8'h00;
                        retry_count_in = 8'h00;
                        rx_count_in    = 8'h00;
                     end
                  end
                  PH_RECEIVE: begin
                     if (rx_count_ff < len) begin
                        mem_we      = 1'b1;
                        rx_count_in = rx_count_ff + 8'd1;
                        if (rx_count_ff < len - 8'd2) begin
                           crc_in = crc_byte(crc_ff, req_chan.rx_byte);
                        end
                     end
                     if (rx_count_in >= len) begin
                        phase_in = PH_EVALUATE;
                     end else begin
                        txv = 1'b1;
                        txb = hist_cmd_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            REQ_FETCH: begin
               mem_ra = AW'(len - 8'd2);
               if (phase_ff == PH_EVALUATE && active_cmd_ff == CMD_READ) begin
                  fetch_hit      = 1'b1;
                  phase_in       = PH_IDLE;
                  active_cmd_in  = CMD_NONE;
                  tick_count_in  = 8'h00;
                  retry_count_in = 8'h00;
                  rx_count_in    = 8'h00;
               end
            end
            REQ_READ: begin
               read_hit = ({2'b00, req_chan.byte_index} < MAX_LEN);
            end
            default: begin
            end
         endcase
      end
   end

   // histogram store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= req_chan.rx_byte;
      end
      if (req_fire) begin
         rda_ff <= hist_mem[mem_ra];
         rdb_ff <= hist_mem[mem_rb];
      end
   end

   // state, configuration and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_cmd_ff   <= POWER_CMD_RST;
         hist_cmd_ff    <= HIST_CMD_RST;
         hist_len_ff    <= HIST_LEN_RST;
         poll_int_ff    <= POLL_INT_RST;
         retry_lim_ff   <= RETRY_LIM_RST;
         phase_ff       <= PH_IDLE;
         active_cmd_ff  <= CMD_NONE;
         tick_count_ff  <= 8'h00;
         retry_count_ff <= 8'h00;
         rx_count_ff    <= 8'h00;
         crc_ff         <= CRC_INIT;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (cfg_we) begin
            unique case (csr_paddr[4:2])
               REG_POWER_CMD: power_cmd_ff <= csr_pwdata[7:0];
               REG_HIST_CMD:  hist_cmd_ff  <= csr_pwdata[7:0];
               REG_HIST_LEN:  hist_len_ff  <= csr_pwdata[7:0];
               REG_POLL_INT:  poll_int_ff  <= csr_pwdata[7:0];
               REG_RETRY_LIM: retry_lim_ff <= csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
         phase_ff       <= phase_in;
         active_cmd_ff  <= active_cmd_in;
         tick_count_ff  <= tick_count_in;
         retry_count_ff <= retry_count_in;
         rx_count_ff    <= rx_count_in;
         crc_ff         <= crc_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      // payload of the middle stage
      if (req_fire) begin
         s1_txv_ff   <= txv;
         s1_txb_ff   <= txb;
         s1_acc_ff   <= acc;
         s1_idle_ff  <= (phase_in == PH_IDLE);
         s1_fetch_ff <= fetch_hit;
         s1_read_ff  <= read_hit;
         s1_crc_ff   <= crc_ff;
      end
      // result payload, checksum compare against the stored bytes
      if (out_free && s1_valid_ff) begin
         out_txv_ff  <= s1_txv_ff;
         out_txb_ff  <= s1_txb_ff;
         out_acc_ff  <= s1_acc_ff;
         out_idle_ff <= s1_idle_ff;
         out_hv_ff   <= s1_fetch_ff;
         out_ok_ff   <= s1_fetch_ff && ({rdb_ff, rda_ff} == s1_crc_ff);
         out_rd_ff   <= s1_read_ff ? rda_ff : 8'h00;
      end
   end

   // result channel
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.tx_valid   = out_txv_ff;
   assign rsp_chan.tx_byte    = out_txb_ff;
   assign rsp_chan.accepted   = out_acc_ff;
   assign rsp_chan.is_idle    = out_idle_ff;
   assign rsp_chan.hist_valid = out_hv_ff;
   assign rsp_chan.crc_ok     = out_ok_ff;
   assign rsp_chan.read_data  = out_rd_ff;

   // an idle sequencer holds no command and no counts
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> active_cmd_ff == CMD_NONE && retry_count_ff == 8'h00
                              && rx_count_ff == 8'h00)
      else $error("idle sequencer holds stale command state");

   // an accepted trigger leaves the sequencer busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.accepted |-> !rsp_chan.is_idle && !rsp_chan.tx_valid)
      else $error("accepted trigger reported with idle or transfer");

   // a completed fetch returns to idle and carries no transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.hist_valid |-> rsp_chan.is_idle && !rsp_chan.tx_valid)
      else $error("histogram fetch did not return to idle");

   // a stalled result register with a full middle stage holds the input back
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready && s1_valid_ff |-> !req_chan.ready)
      else $error("input taken while pipeline is full");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import sscs_pkg::*;

   // request codes the block ignores
   localparam logic [2:0] REQ_RSVD_5 = 3'd5;
   localparam logic [2:0] REQ_RSVD_6 = 3'd6;
   localparam logic [2:0] REQ_RSVD_7 = 3'd7;

   localparam int HIST_DEPTH = MAX_HIST_BYTES_DEF;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WAIT,
      SEQ_POLL_REPLY,
      SEQ_DATA_REPLY,
      SEQ_RECEIVE,
      SEQ_EVALUATE
   } seq_phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] cmd_index;
      logic [7:0] rx_byte;
      logic [6:0] byte_index;
   } seq_req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       accepted;
      logic       is_idle;
      logic       hist_valid;
      logic       crc_ok;
      logic [7:0] read_data;
   } seq_rsp_type;

   // tracks sequencer state and holds the results still to come
   class sequencer_checker;
      logic [7:0]    power_cmd;
      logic [7:0]    hist_cmd;
      logic [7:0]    hist_len;
      logic [7:0]    poll_int;
      logic [7:0]    retry_lim;
      seq_phase_type phase;
      logic [2:0]    active_cmd;
      logic [7:0]    ticks;
      logic [7:0]    retries;
      logic [7:0]    rx_cnt;
      logic [15:0]   crc;
      logic [7:0]    store [HIST_DEPTH];
      int            stored_bytes;
      seq_rsp_type   pending_rsp [$];
      int            fails;

      function new();
         power_cmd    = POWER_CMD_RST;
         hist_cmd     = HIST_CMD_RST;
         hist_len     = HIST_LEN_RST;
         poll_int     = POLL_INT_RST;
         retry_lim    = RETRY_LIM_RST;
         crc          = CRC_INIT;
         stored_bytes = 0;
         fails        = 0;
         go_idle();
      endfunction

      function void go_idle();
         phase      = SEQ_IDLE;
         active_cmd = CMD_NONE;
         ticks      = 8'd0;
         retries    = 8'd0;
         rx_cnt     = 8'd0;
      endfunction

      function void give_up_or_wait();
         if (retries > retry_lim) begin
            go_idle();
         end else begin
            phase = SEQ_WAIT;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] v);
         unique case (idx)
            REG_POWER_CMD: power_cmd = v;
            REG_HIST_CMD:  hist_cmd = v;
            REG_HIST_LEN:  hist_len = v;
            REG_POLL_INT:  poll_int = v;
            REG_RETRY_LIM: retry_lim = v;
            default: ;
         endcase
      endfunction

      // histogram length clamped to the minimum and to what the store can hold
      function int hist_span();
         int l;
         l = hist_len;
         if (l < 3) l = 3;
         if (l > HIST_DEPTH) l = HIST_DEPTH;
         return l;
      endfunction

      // reflected crc-16, one byte lsb first
      function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         end
         return r;
      endfunction

      // step the sequencer on one accepted item and queue its result
      function void note_request(seq_req_type q);
         seq_rsp_type e;
         int          len;
         logic [15:0] rcv;
         e   = '0;
         len = hist_span();
         unique case (q.req_type)
            REQ_TRIGGER: begin
               if (phase == SEQ_IDLE && q.cmd_index != CMD_NONE) begin
                  active_cmd = q.cmd_index;
                  ticks      = 8'd0;
                  retries    = 8'd0;
                  phase      = SEQ_WAIT;
                  e.accepted = 1'b1;
               end
            end
            REQ_TICK: begin
               if (phase == SEQ_WAIT) begin
                  if (ticks != 8'hFF) ticks++;
                  if (ticks > poll_int) begin
                     ticks = 8'd0;
                     if (retries != 8'hFF) retries++;
                     e.tx_valid = 1'b1;
                     e.tx_byte  = (active_cmd == CMD_READ) ? hist_cmd : power_cmd;
                     phase      = SEQ_POLL_REPLY;
                  end
               end
            end
            REQ_REPLY: begin
               unique case (phase)
                  SEQ_POLL_REPLY: begin
                     if (q.rx_byte == RES_READY) begin
                        e.tx_valid = 1'b1;
                        if (active_cmd == CMD_READ) begin
                           rx_cnt    = 8'd0;
                           crc       = CRC_INIT;
                           e.tx_byte = hist_cmd;
                           phase     = SEQ_RECEIVE;
                        end else begin
                           e.tx_byte = 8'(active_cmd) + 8'd2;
                           phase     = SEQ_DATA_REPLY;
                        end
                     end else begin
                        give_up_or_wait();
                     end
                  end
                  SEQ_DATA_REPLY: begin
                     if (q.rx_byte == RES_BUSY) begin
                        give_up_or_wait();
                     end else begin
                        go_idle();
                     end
                  end
                  SEQ_RECEIVE: begin
                     if (int'(rx_cnt) < len) begin
                        store[rx_cnt] = q.rx_byte;
                        if (int'(rx_cnt) >= stored_bytes) stored_bytes = int'(rx_cnt) + 1;
                        if (int'(rx_cnt) < len - 2) crc = crc_update(crc, q.rx_byte);
                        rx_cnt++;
                     end
                     if (int'(rx_cnt) >= len) begin
                        phase = SEQ_EVALUATE;
                     end else begin
                        e.tx_valid = 1'b1;
                        e.tx_byte  = hist_cmd;
                     end
                  end
                  default: ;
               endcase
            end
            REQ_FETCH: begin
               if (phase == SEQ_EVALUATE && active_cmd == CMD_READ) begin
                  // checksum sits little endian in the last two bytes
                  rcv          = {store[len - 1], store[len - 2]};
                  e.hist_valid = 1'b1;
                  e.crc_ok     = (rcv == crc);
                  go_idle();
               end
            end
            REQ_READ: begin
               e.read_data = store[q.byte_index];
            end
            default: ;
         endcase
         e.is_idle = (phase == SEQ_IDLE);
         pending_rsp.push_back(e);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
         end
      endfunction

      function void check_response(seq_rsp_type got);
         seq_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("result arrived with no item outstanding");
            fails++;
            return;
         end
         want = pending_rsp.pop_front();
         check_field("tx_valid", want.tx_valid, got.tx_valid);
         check_field("tx_byte", want.tx_byte, got.tx_byte);
         check_field("accepted", want.accepted, got.accepted);
         check_field("is_idle", want.is_idle, got.is_idle);
         check_field("hist_valid", want.hist_valid, got.hist_valid);
         check_field("crc_ok", want.crc_ok, got.crc_ok);
         check_field("read_data", want.read_data, got.read_data);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        rsp_ready_q = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   sequencer_checker seq_chk;

   sscs_req_if req_chan ();
   sscs_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_ready_q;

   spi_sensor_command_sequencer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted results, stall at random
   always @(posedge clock) begin : rsp_sink
      seq_rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.tx_valid   = rsp_chan.tx_valid;
         got.tx_byte    = rsp_chan.tx_byte;
         got.accepted   = rsp_chan.accepted;
         got.is_idle    = rsp_chan.is_idle;
         got.hist_valid = rsp_chan.hist_valid;
         got.crc_ok     = rsp_chan.crc_ok;
         got.read_data  = rsp_chan.read_data;
         seq_chk.check_response(got);
      end
      rsp_ready_q <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // run limit
   initial begin
      #5000000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic seq_req_type mk_req(logic [2:0] t, logic [2:0] c, logic [7:0] rx,
                                          logic [6:0] bi);
      seq_req_type q;
      q.req_type   = t;
      q.cmd_index  = c;
      q.rx_byte    = rx;
      q.byte_index = bi;
      return q;
   endfunction

   // mostly well-formed traffic for the current phase, some noise
   function automatic seq_req_type pick_request(int ready_pct);
      seq_req_type q;
      int          roll;
      int          len;
      q.req_type   = 3'($urandom_range(0, 7));
      q.cmd_index  = 3'($urandom());
      q.rx_byte    = 8'($urandom());
      q.byte_index = 7'($urandom());
      len          = seq_chk.hist_span();
      roll         = $urandom_range(0, 99);
      if (roll >= 10) begin
         roll = $urandom_range(0, 99);
         unique case (seq_chk.phase)
            SEQ_IDLE: begin
               if (roll < 70) begin
                  q.req_type = REQ_TRIGGER;
               end else if (roll < 85) begin
                  q.req_type = REQ_READ;
               end else begin
                  q.req_type = 3'($urandom_range(REQ_TICK, REQ_FETCH));
               end
            end
            SEQ_WAIT: q.req_type = (roll < 92) ? REQ_TICK : REQ_READ;
            SEQ_POLL_REPLY: begin
               q.req_type = REQ_REPLY;
               if (roll < ready_pct) begin
                  q.rx_byte = RES_READY;
               end else if ($urandom_range(0, 1) == 1) begin
                  q.rx_byte = RES_BUSY;
               end
            end
            SEQ_DATA_REPLY: begin
               q.req_type = REQ_REPLY;
               if (roll < 50) q.rx_byte = RES_BUSY;
            end
            SEQ_RECEIVE: begin
               q.req_type = (roll < 95) ? REQ_REPLY : REQ_READ;
               // usually send back a matching checksum
               if ($urandom_range(0, 3) != 0) begin
                  if (int'(seq_chk.rx_cnt) == len - 2) begin
                     q.rx_byte = seq_chk.crc[7:0];
                  end else if (int'(seq_chk.rx_cnt) == len - 1) begin
                     q.rx_byte = seq_chk.crc[15:8];
                  end
               end
            end
            SEQ_EVALUATE: q.req_type = (roll < 85) ? REQ_FETCH : REQ_READ;
            default: ;
         endcase
      end
      // reads only touch bytes already received
      if (q.req_type == REQ_READ) begin
         if (seq_chk.stored_bytes == 0) begin
            q.req_type = REQ_TICK;
         end else begin
            q.byte_index = 7'($urandom_range(0, seq_chk.stored_bytes - 1));
         end
      end
      return q;
   endfunction

   task automatic send_request(input seq_req_type q);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= q.req_type;
      req_chan.cmd_index  <= q.cmd_index;
      req_chan.rx_byte    <= q.rx_byte;
      req_chan.byte_index <= q.byte_index;
      do @(posedge clock); while (!req_chan.ready);
      seq_chk.note_request(q);
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   task automatic wait_all_results();
      do @(posedge clock); while (seq_chk.pending_rsp.size() != 0);
   endtask

   task automatic set_mode(input int m);
      unique case (m)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
         default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
      endcase
   endtask

   // apb write: setup phase, then access phase
   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seq_chk.write_reg(idx, val);
   endtask

   task automatic apply_setting(input logic [7:0] pc, input logic [7:0] hc,
                                input logic [7:0] hl, input logic [7:0] pi,
                                input logic [7:0] rl);
      csr_write(REG_POWER_CMD, pc);
      csr_write(REG_HIST_CMD, hc);
      csr_write(REG_HIST_LEN, hl);
      csr_write(REG_POLL_INT, pi);
      csr_write(REG_RETRY_LIM, rl);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // walk the sequencer back to idle, then let every result drain
   task automatic settle();
      seq_req_type q;
      set_mode(0);
      while (seq_chk.phase != SEQ_IDLE) begin
         unique case (seq_chk.phase)
            SEQ_WAIT:       q = mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0);
            SEQ_POLL_REPLY: q = mk_req(REQ_REPLY, CMD_NONE, RES_READY, 7'd0);
            SEQ_DATA_REPLY: q = mk_req(REQ_REPLY, CMD_NONE, 8'h00, 7'd0);
            SEQ_RECEIVE:    q = mk_req(REQ_REPLY, CMD_NONE, 8'($urandom()), 7'd0);
            default:        q = mk_req(REQ_FETCH, CMD_NONE, 8'h00, 7'd0);
         endcase
         send_request(q);
      end
      req_chan.valid <= 1'b0;
      wait_all_results();
   endtask

   task automatic run_random(input int n_items, input int ready_pct, input int pause_at,
                             input int mode_base);
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) set_mode((i / 40 + mode_base) % 4);
         // hold off until every outstanding result is back
         if (i == pause_at) begin
            req_chan.valid <= 1'b0;
            wait_all_results();
         end
         idle_gap();
         send_request(pick_request(ready_pct));
      end
   endtask

   // stimulus
   initial begin
      seq_chk = new();
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_TRIGGER;
      req_chan.cmd_index  <= CMD_NONE;
      req_chan.rx_byte    <= 8'h00;
      req_chan.byte_index <= 7'd0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= 5'd0;
      csr_pwdata          <= 32'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: short histogram, poll on every tick, one retry allowed
      apply_setting(8'hFF, 8'h00, 8'd3, 8'd0, 8'd1);
      send_request(mk_req(REQ_FETCH, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_READY, 7'd0));
      send_request(mk_req(REQ_TRIGGER, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_RSVD_7, 3'b111, 8'hFF, 7'h7F));
      send_request(mk_req(REQ_RSVD_6, 3'b000, 8'h00, 7'd0));
      send_request(mk_req(REQ_RSVD_5, 3'b101, 8'hA5, 7'h2A));
      // power write: busy once, then busy on data until retries run out
      send_request(mk_req(REQ_TRIGGER, 3'd0, 8'h00, 7'd0));
      send_request(mk_req(REQ_TRIGGER, 3'd1, 8'h00, 7'd0));
      send_request(mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_BUSY, 7'd0));
      send_request(mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_READY, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_BUSY, 7'd0));
      // power write with the highest data code
      send_request(mk_req(REQ_TRIGGER, 3'd5, 8'h00, 7'd0));
      send_request(mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_READY, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, 8'h00, 7'd0));
      // histogram read with a good checksum, then fetch and read back
      send_request(mk_req(REQ_TRIGGER, CMD_READ, 8'h00, 7'd0));
      send_request(mk_req(REQ_TICK, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, RES_READY, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, 8'hFF, 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, seq_chk.crc[7:0], 7'd0));
      send_request(mk_req(REQ_REPLY, CMD_NONE, seq_chk.crc[15:8], 7'd0));
      send_request(mk_req(REQ_FETCH, CMD_NONE, 8'h00, 7'd0));
      send_request(mk_req(REQ_READ, CMD_NONE, 8'h00, 7'd2));
      run_random(100, 70, -1, 0);

      // full store, never give up
      settle();
      apply_setting(8'hA5, 8'h5A, 8'd128, 8'd1, 8'd255);
      run_random(110, 80, -1, 1);

      // random setting, with one hold-off mid-run
      settle();
      apply_setting(8'($urandom()), 8'($urandom()), 8'($urandom_range(3, 12)),
                    8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)));
      run_random(110, 50, 60, 2);

      // length below range, give up on the first miss
      settle();
      apply_setting(8'h00, 8'hFF, 8'd0, 8'd2, 8'd0);
      run_random(70, 60, -1, 3);

      // sensor stays busy long enough for the retry count to saturate
      settle();
      apply_setting(8'h3C, 8'hC3, 8'd5, 8'd0, 8'd255);
      run_random(640, 0, -1, 0);

      // length above range
      settle();
      apply_setting(8'h81, 8'h7E, 8'd255, 8'd0, 8'd2);
      run_random(90, 80, -1, 1);

      // longest poll interval: a started command never polls
      settle();
      apply_setting(8'h55, 8'hAA, 8'd4, 8'd255, 8'd0);
      run_random(40, 60, -1, 2);

      req_chan.valid <= 1'b0;
      wait_all_results();
      repeat (8) @(posedge clock);
      if (seq_chk.fails == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
